>>> hw/rtl/bbsis_pkg.sv
// bbsis_pkg: shared codes and constants of the cubic b-spline image scaler
// used by bicubic_bspline_image_scaler and bbsis_norm; no dependencies
package bbsis_pkg;

  // item kinds carried on tuser
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEP_X     = 2'd2;
  localparam logic [1:0] REG_STEP_Y     = 2'd3;

  localparam int SIZE_W  = 9;
  localparam int STEP_W  = 24;
  localparam int COORD_W = 12;
  localparam int SRC_W   = 8;
  localparam int PIX_W   = 24;
  localparam int CHAN_W  = 8;

  localparam logic [SIZE_W-1:0] SIZE_RST = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RST = 24'd65536;

  // division by six of a pass sum, after the fraction bits are dropped
  localparam int            NORM_X_W   = 13;
  localparam logic [12:0]   NORM_SAT_X = 13'd1536;
  localparam logic [13:0]   RECIP_6    = 14'd10923;
  localparam int            RECIP_SH   = 16;

endpackage

>>> hw/rtl/bicubic_bspline_image_scaler.sv
// bicubic_bspline_image_scaler: frame store plus cubic b-spline resampler, rgb out
// depends on bbsis_pkg and bbsis_norm
//
// A write item stores one pixel in the frame store and gives no result. A compute item maps
// the coordinate, builds the weights of both axes, reads the sixteen taps and runs the three
// horizontal passes row by row, then runs the vertical passes and waits in its last state
// until the result register is free. The one shared multiplier does every product in turn,
// and the single-port frame store is read one tap at a time. The block takes no item while
// a compute item is in work, but takes the next one while the result waits to be taken.
// The frame store needs no clearing after reset.
module bicubic_bspline_image_scaler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // src_col, src_row, src_pixel, out_col, out_row
  input  logic [71:0] in_tdata,
  // opcode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // res_col, res_row, red, green, blue
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int F      = FRAC_BITS;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SZW_X  = $clog2(MAX_WIDTH + 1);
  localparam int SZW_Y  = $clog2(MAX_HEIGHT + 1);
  localparam int POS_W  = bbsis_pkg::COORD_W + bbsis_pkg::STEP_W;
  localparam int BX_W   = POS_W - F;
  localparam int WGT_W  = F + 3;
  localparam int MA_W   = (F + 1 > bbsis_pkg::COORD_W) ? F + 1 : bbsis_pkg::COORD_W;
  localparam int MB_W   = (WGT_W > bbsis_pkg::STEP_W) ? WGT_W : bbsis_pkg::STEP_W;
  localparam int P_W    = MA_W + MB_W;
  localparam int ACC_W  = F + 13;
  localparam int CW     = bbsis_pkg::CHAN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PX, S_PY, S_T2, S_T3, S_UU, S_U3, S_WGT,
    S_RD, S_HMAC, S_HSUM, S_HNORM, S_VMAC, S_VSUM, S_VNORM
  } state_t;

  state_t state_r, state_nxt, tag_r;
  logic [1:0] i_r, j_r, c_r, tag_i_r, tag_j_r, tag_c_r;
  logic       ax_r;

  logic [bbsis_pkg::SIZE_W-1:0] width_r, height_r;
  logic [bbsis_pkg::STEP_W-1:0] step_x_r, step_y_r;

  logic [bbsis_pkg::COORD_W-1:0] ocol_r, orow_r;
  logic [P_W-1:0]   prod_r;
  logic [BX_W-1:0]  bx_r, by_r;
  logic [F-1:0]     tx_r, ty_r, t2_r, t3_r;
  logic [WGT_W-1:0] wx_r [4];
  logic [WGT_W-1:0] wy_r [4];
  logic [ACC_W-1:0] acc_h_r [3];
  logic [ACC_W-1:0] acc_v_r [3];
  logic [CW-1:0]    colv_r [4][3];
  logic [bbsis_pkg::PIX_W-1:0] rd_r;
  logic [bbsis_pkg::PIX_W-1:0] mem [DEPTH];

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;

  // input fields
  logic [bbsis_pkg::SRC_W-1:0]   in_src_col, in_src_row;
  logic [31:0]                   in_src_pixel;
  logic [bbsis_pkg::COORD_W-1:0] in_out_col, in_out_row;

  assign in_src_col   = in_tdata[7:0];
  assign in_src_row   = in_tdata[15:8];
  assign in_src_pixel = in_tdata[47:16];
  assign in_out_col   = in_tdata[59:48];
  assign in_out_row   = in_tdata[71:60];

  logic accept, cfg_we, out_free;
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    case (cfg_paddr[3:2])
      bbsis_pkg::REG_SRC_WIDTH:  cfg_prdata = 32'(width_r);
      bbsis_pkg::REG_SRC_HEIGHT: cfg_prdata = 32'(height_r);
      bbsis_pkg::REG_STEP_X:     cfg_prdata = 32'(step_x_r);
      bbsis_pkg::REG_STEP_Y:     cfg_prdata = 32'(step_y_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // effective source size
  logic [SZW_X-1:0] eff_w;
  logic [SZW_Y-1:0] eff_h;
  always_comb begin
    if (width_r == '0) begin
      eff_w = SZW_X'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = SZW_X'(MAX_WIDTH);
    end else begin
      eff_w = SZW_X'(width_r);
    end
    if (height_r == '0) begin
      eff_h = SZW_Y'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = SZW_Y'(MAX_HEIGHT);
    end else begin
      eff_h = SZW_Y'(height_r);
    end
  end

  // clamped tap coordinates
  logic [BX_W+1:0]  xt, yt, lim_x, lim_y;
  logic [COL_W-1:0] x_idx;
  logic [ROW_W-1:0] y_idx;
  always_comb begin
    xt    = {2'b00, bx_r} + (BX_W+2)'(i_r) - (BX_W+2)'(1);
    yt    = {2'b00, by_r} + (BX_W+2)'(j_r) - (BX_W+2)'(1);
    lim_x = (BX_W+2)'(eff_w - SZW_X'(1));
    lim_y = (BX_W+2)'(eff_h - SZW_Y'(1));
    if (xt[BX_W+1]) begin
      x_idx = '0;
    end else if (xt > lim_x) begin
      x_idx = COL_W'(lim_x);
    end else begin
      x_idx = COL_W'(xt);
    end
    if (yt[BX_W+1]) begin
      y_idx = '0;
    end else if (yt > lim_y) begin
      y_idx = ROW_W'(lim_y);
    end else begin
      y_idx = ROW_W'(yt);
    end
  end

  // frame store port
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  assign mem_we = accept && (in_tuser == bbsis_pkg::OP_WRITE) &&
                  (32'(in_src_col) < MAX_WIDTH) && (32'(in_src_row) < MAX_HEIGHT);
  assign mem_re = (state_r == S_RD);
  assign mem_addr = (state_r == S_IDLE) ?
      ADDR_W'(32'(in_src_row) * MAX_WIDTH + 32'(in_src_col)) :
      ADDR_W'(32'(y_idx) * MAX_WIDTH + 32'(x_idx));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_src_pixel[bbsis_pkg::PIX_W-1:0];
    end
    if (mem_re) begin
      rd_r <= mem[mem_addr];
    end
  end

  // shared multiplier operands
  logic [F-1:0]     t_cur;
  logic [F:0]       u_cur;
  logic [CW-1:0]    chan;
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  assign t_cur = ax_r ? ty_r : tx_r;
  assign u_cur = (F+1)'(1) << F;
  logic [F:0] u_val;
  assign u_val = u_cur - (F+1)'(t_cur);

  always_comb begin
    case (c_r)
      2'd0:    chan = rd_r[23:16];
      2'd1:    chan = rd_r[15:8];
      default: chan = rd_r[7:0];
    endcase
  end

  always_comb begin
    case (state_r)
      S_PX: begin
        mul_a = MA_W'(ocol_r);
        mul_b = MB_W'(step_x_r);
      end
      S_PY: begin
        mul_a = MA_W'(orow_r);
        mul_b = MB_W'(step_y_r);
      end
      S_T2: begin
        mul_a = MA_W'(t_cur);
        mul_b = MB_W'(t_cur);
      end
      S_T3: begin
        mul_a = MA_W'(prod_r >> F);
        mul_b = MB_W'(t_cur);
      end
      S_UU: begin
        mul_a = MA_W'(u_val);
        mul_b = MB_W'(u_val);
      end
      S_U3: begin
        mul_a = MA_W'(prod_r >> F);
        mul_b = MB_W'(u_val);
      end
      S_HMAC: begin
        mul_a = MA_W'(chan);
        mul_b = MB_W'(wx_r[i_r]);
      end
      S_VMAC: begin
        mul_a = MA_W'(colv_r[j_r][c_r]);
        mul_b = MB_W'(wy_r[j_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // weights from t, t2, t3 and the u cube waiting in the product register
  logic [WGT_W-1:0] w0_c, w1_c, w2_c, w3_c;
  assign w0_c = WGT_W'(prod_r >> F);
  assign w1_c = WGT_W'(32'(t3_r) * 3 - 32'(t2_r) * 6 + (32'(4) << F));
  assign w2_c = WGT_W'(32'(t2_r) * 3 + 32'(t_cur) * 3 + (32'(1) << F) - 32'(t3_r) * 3);
  assign w3_c = WGT_W'(t3_r);

  logic [CW-1:0] norm_q [3];
  for (genvar k = 0; k < 3; k++) begin : g_norm
    bbsis_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
      .acc_i ((state_r == S_HNORM) ? acc_h_r[k] : acc_v_r[k]),
      .q_o   (norm_q[k])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && in_tuser == bbsis_pkg::OP_COMPUTE) state_nxt = S_PX;
      S_PX:    state_nxt = S_PY;
      S_PY:    state_nxt = S_T2;
      S_T2:    state_nxt = S_T3;
      S_T3:    state_nxt = S_UU;
      S_UU:    state_nxt = S_U3;
      S_U3:    state_nxt = S_WGT;
      S_WGT:   state_nxt = ax_r ? S_RD : S_T2;
      S_RD:    state_nxt = S_HMAC;
      S_HMAC: begin
        if (c_r == 2'd2) state_nxt = (i_r == 2'd3) ? S_HSUM : S_RD;
      end
      S_HSUM:  state_nxt = S_HNORM;
      S_HNORM: state_nxt = (j_r == 2'd3) ? S_VMAC : S_RD;
      S_VMAC: begin
        if (c_r == 2'd2 && j_r == 2'd3) state_nxt = S_VSUM;
      end
      S_VSUM:  state_nxt = S_VNORM;
      S_VNORM: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tag_r        <= S_IDLE;
      out_tvalid_r <= 1'b0;
      width_r      <= bbsis_pkg::SIZE_RST;
      height_r     <= bbsis_pkg::SIZE_RST;
      step_x_r     <= bbsis_pkg::STEP_RST;
      step_y_r     <= bbsis_pkg::STEP_RST;
      ax_r         <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      c_r          <= '0;
      tag_i_r      <= '0;
      tag_j_r      <= '0;
      tag_c_r      <= '0;
    end else begin
      state_r <= state_nxt;
      tag_r   <= state_r;
      tag_i_r <= i_r;
      tag_j_r <= j_r;
      tag_c_r <= c_r;
      if (cfg_we) begin
        case (cfg_paddr[3:2])
          bbsis_pkg::REG_SRC_WIDTH:  width_r  <= cfg_pwdata[bbsis_pkg::SIZE_W-1:0];
          bbsis_pkg::REG_SRC_HEIGHT: height_r <= cfg_pwdata[bbsis_pkg::SIZE_W-1:0];
          bbsis_pkg::REG_STEP_X:     step_x_r <= cfg_pwdata[bbsis_pkg::STEP_W-1:0];
          bbsis_pkg::REG_STEP_Y:     step_y_r <= cfg_pwdata[bbsis_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_PX: begin
          ax_r <= 1'b0;
          i_r  <= '0;
          j_r  <= '0;
          c_r  <= '0;
        end
        S_WGT: ax_r <= 1'b1;
        S_HMAC: begin
          if (c_r == 2'd2) begin
            c_r <= '0;
            i_r <= i_r + 2'd1;
          end else begin
            c_r <= c_r + 2'd1;
          end
        end
        S_HNORM: begin
          j_r <= j_r + 2'd1;
          c_r <= '0;
        end
        S_VMAC: begin
          if (c_r == 2'd2) begin
            c_r <= '0;
            j_r <= j_r + 2'd1;
          end else begin
            c_r <= c_r + 2'd1;
          end
        end
        default: ;
      endcase
      if (state_r == S_VNORM && out_free) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {norm_q[2], norm_q[1], norm_q[0], orow_r, ocol_r};
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= P_W'(mul_a) * P_W'(mul_b);
    if (accept) begin
      ocol_r <= in_out_col;
      orow_r <= in_out_row;
    end
    case (tag_r)
      S_PX: begin
        bx_r <= BX_W'(prod_r >> F);
        tx_r <= prod_r[F-1:0];
      end
      S_PY: begin
        by_r <= BX_W'(prod_r >> F);
        ty_r <= prod_r[F-1:0];
      end
      S_T2: t2_r <= F'(prod_r >> F);
      S_T3: t3_r <= F'(prod_r >> F);
      S_HMAC: begin
        acc_h_r[tag_c_r] <= ((tag_i_r == 2'd0) ? '0 : acc_h_r[tag_c_r]) +
                            prod_r[ACC_W-1:0];
      end
      S_VMAC: begin
        acc_v_r[tag_c_r] <= ((tag_j_r == 2'd0) ? '0 : acc_v_r[tag_c_r]) +
                            prod_r[ACC_W-1:0];
      end
      default: ;
    endcase
    if (state_r == S_WGT) begin
      if (ax_r) begin
        wy_r[0] <= w0_c;
        wy_r[1] <= w1_c;
        wy_r[2] <= w2_c;
        wy_r[3] <= w3_c;
      end else begin
        wx_r[0] <= w0_c;
        wx_r[1] <= w1_c;
        wx_r[2] <= w2_c;
        wx_r[3] <= w3_c;
      end
    end
    if (state_r == S_HNORM) begin
      colv_r[j_r][0] <= norm_q[0];
      colv_r[j_r][1] <= norm_q[1];
      colv_r[j_r][2] <= norm_q[2];
    end
  end

endmodule

>>> hw/rtl/bbsis_norm.sv
// bbsis_norm: scales one spline pass sum down by six units of one and saturates to a channel
// depends on bbsis_pkg
module bbsis_norm #(
  parameter int FRAC_BITS = 16
) (
  input  logic [FRAC_BITS+12:0]       acc_i,
  output logic [bbsis_pkg::CHAN_W-1:0] q_o
);

  localparam int PR_W  = 25;

  logic [bbsis_pkg::NORM_X_W-1:0] x;
  logic [PR_W-1:0]                prod;

  assign x    = bbsis_pkg::NORM_X_W'(acc_i >> FRAC_BITS);
  assign prod = PR_W'(x[10:0]) * PR_W'(bbsis_pkg::RECIP_6);

  always_comb begin
    if (x >= bbsis_pkg::NORM_SAT_X) begin
      q_o = 8'hff;
    end else begin
      q_o = prod[bbsis_pkg::RECIP_SH +: bbsis_pkg::CHAN_W];
    end
  end

endmodule
